/* hw/rtl/ezq_pkg.sv */
// Shared constants, types and a rounding helper for the Euler-to-quaternion block.
`timescale 1ns / 1ps

package ezq_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;
    localparam int FX             = 30;
    localparam int N_STEPS        = 9;

    localparam logic [31:0] ONE_FX  = 32'd1 << FX;
    localparam logic [63:0] HALF_FX = 64'd1 << (FX - 1);
    localparam logic [31:0] PI_Q30  = 32'd3373259426;

    typedef struct packed {
        logic signed [31:0] sin_val;
        logic signed [31:0] cos_val;
    } sc_t;

    function automatic logic signed [63:0] rnd_q30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] res;
        begin
            mag = v[63] ? 64'(-v) : 64'(v);
            res = (mag + HALF_FX) >> FX;
            rnd_q30 = v[63] ? -$signed(res) : $signed(res);
        end
    endfunction

endpackage

/* hw/rtl/ezq_sincos.sv */
// Pipelined sine and cosine of a half binary angle by a fixed Taylor series.
`timescale 1ns / 1ps

module ezq_sincos
    import ezq_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output sc_t                   result
);

    localparam int PW = ANGLE_BITS + 32;
    localparam int XD = 3 * N_STEPS + 1;
    localparam int QD = 3 * N_STEPS - 2;
    localparam logic [PW-1:0] HALF_IN = PW'(1) << (ANGLE_BITS - 1);

    logic                  neg0_reg, neg0_next;
    logic [ANGLE_BITS-1:0] mag0_reg, mag0_next;
    logic                  neg1_reg, neg1_next;
    logic [PW-1:0]         prod1_reg, prod1_next;
    logic                  neg2_reg, neg2_next;
    logic [31:0]           xr_reg, xr_next;
    logic                  neg3_reg, neg3_next;
    logic [31:0]           x3_reg, x3_next;
    logic [63:0]           sq_reg, sq_next;

    logic [31:0] xsq_d_reg [QD];
    logic [31:0] xsq_d_next [QD];
    logic [31:0] x_d_reg [XD];
    logic [31:0] x_d_next [XD];
    logic        neg_d_reg [XD];
    logic        neg_d_next [XD];

    logic [31:0]        ts_in [N_STEPS];
    logic [31:0]        tc_in [N_STEPS];
    logic signed [32:0] ts_out [N_STEPS];
    logic signed [32:0] tc_out [N_STEPS];

    logic [63:0]        fs_reg, fs_next;
    logic signed [32:0] tc1_reg, tc1_next;
    logic               negf_reg, negf_next;
    sc_t                res_reg, res_next;
    logic [63:0]        s_mag;

    always_comb
    begin
        neg0_next  = angle[ANGLE_BITS-1];
        mag0_next  = angle[ANGLE_BITS-1] ? ANGLE_BITS'(~angle + 1'b1) : angle;
        neg1_next  = neg0_reg;
        prod1_next = PW'(mag0_reg) * PW'(PI_Q30);
        neg2_next  = neg1_reg;
        xr_next    = 32'((prod1_reg + HALF_IN) >> ANGLE_BITS);
        neg3_next  = neg2_reg;
        x3_next    = xr_reg;
        sq_next    = 64'(xr_reg) * 64'(xr_reg);
        xsq_d_next[0] = 32'((sq_reg + HALF_FX) >> FX);
        x_d_next[0]   = x3_reg;
        neg_d_next[0] = neg3_reg;
        for (int i = 1; i < QD; i++)
        begin
            xsq_d_next[i] = xsq_d_reg[i-1];
        end
        for (int i = 1; i < XD; i++)
        begin
            x_d_next[i]   = x_d_reg[i-1];
            neg_d_next[i] = neg_d_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg0_reg  <= neg0_next;
            mag0_reg  <= mag0_next;
            neg1_reg  <= neg1_next;
            prod1_reg <= prod1_next;
            neg2_reg  <= neg2_next;
            xr_reg    <= xr_next;
            neg3_reg  <= neg3_next;
            x3_reg    <= x3_next;
            sq_reg    <= sq_next;
            xsq_d_reg <= xsq_d_next;
            x_d_reg   <= x_d_next;
            neg_d_reg <= neg_d_next;
        end
    end

    for (genvar j = 0; j < N_STEPS; j++)
    begin : g_step
        localparam int K  = N_STEPS - j;
        localparam int DS = (2 * K) * (2 * K + 1);
        localparam int DC = (2 * K - 1) * (2 * K);
        localparam int SS = 32 + $clog2(DS);
        localparam int SC = 32 + $clog2(DC);
        localparam logic [33:0] MS = 34'(((66'd1 << SS) + 66'(DS) - 66'd1) / 66'(DS));
        localparam logic [33:0] MC = 34'(((66'd1 << SC) + 66'(DC) - 66'd1) / 66'(DC));
        localparam logic [63:0] PRE_S = HALF_FX + (64'(DS / 2) << FX);
        localparam logic [63:0] PRE_C = HALF_FX + (64'(DC / 2) << FX);

        logic [63:0] ps_reg, ps_next, pc_reg, pc_next;
        logic [31:0] ns_reg, ns_next, nc_reg, nc_next;
        logic [65:0] qs_reg, qs_next, qc_reg, qc_next;

        if (j == 0)
        begin : g_first
            assign ts_in[j] = ONE_FX;
            assign tc_in[j] = ONE_FX;
        end
        else
        begin : g_next
            assign ts_in[j] = 32'(ts_out[j-1]);
            assign tc_in[j] = 32'(tc_out[j-1]);
        end

        always_comb
        begin
            ps_next = 64'(xsq_d_reg[3*j]) * 64'(ts_in[j]);
            pc_next = 64'(xsq_d_reg[3*j]) * 64'(tc_in[j]);
            ns_next = 32'((ps_reg + PRE_S) >> FX);
            nc_next = 32'((pc_reg + PRE_C) >> FX);
            qs_next = 66'(ns_reg) * 66'(MS);
            qc_next = 66'(nc_reg) * 66'(MC);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ps_reg <= ps_next;
                pc_reg <= pc_next;
                ns_reg <= ns_next;
                nc_reg <= nc_next;
                qs_reg <= qs_next;
                qc_reg <= qc_next;
            end
        end

        assign ts_out[j] = $signed({1'b0, ONE_FX}) - $signed({1'b0, 32'(qs_reg >> SS)});
        assign tc_out[j] = $signed({1'b0, ONE_FX}) - $signed({1'b0, 32'(qc_reg >> SC)});
    end

    always_comb
    begin
        fs_next   = 64'(x_d_reg[XD-1]) * 64'(32'(ts_out[N_STEPS-1]));
        tc1_next  = tc_out[N_STEPS-1];
        negf_next = neg_d_reg[XD-1];
        s_mag     = (fs_reg + HALF_FX) >> FX;
        if (s_mag > 64'(ONE_FX))
        begin
            s_mag = 64'(ONE_FX);
        end
        res_next.sin_val = negf_reg ? -$signed(32'(s_mag)) : $signed(32'(s_mag));
        if (tc1_reg < 0)
        begin
            res_next.cos_val = '0;
        end
        else if (tc1_reg > $signed({1'b0, ONE_FX}))
        begin
            res_next.cos_val = $signed(ONE_FX);
        end
        else
        begin
            res_next.cos_val = 32'(tc1_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fs_reg   <= fs_next;
            tc1_reg  <= tc1_next;
            negf_reg <= negf_next;
            res_reg  <= res_next;
        end
    end

    assign result = res_reg;

endmodule

/* hw/rtl/euler_zyx_to_quaternion_top.sv */
// Top level: ZYX Euler angles to a unit quaternion in signed fixed point.
`timescale 1ns / 1ps

// The block turns roll, pitch and yaw binary angles (a full turn is 2^ANGLE_BITS)
// into the quaternion components w, x, y and z in signed Q1.FRAC_BITS.
// Input beats arrive on the s_ group and results leave on the m_ group.
// Each accepted input beat gives exactly one output beat, in order.
// Throughput is one beat per cycle while the receiver is ready.
// The series pipeline holds nine Horner steps of three stages each.
// The whole pipeline advances together when the output stage is empty or taken.
// When the receiver stalls with a beat waiting, every stage holds its data.
// s_tready then drops, and no beat is lost or repeated.
// Reset clears all valid bits, so the block starts empty and ready.
// The block keeps no state between beats and has no configuration.

module euler_zyx_to_quaternion_top
    import ezq_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // Fields from bit 0 up: roll_angle, pitch_angle, yaw_angle.
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // Fields from bit 0 up: quat_w, quat_x, quat_y, quat_z.
    output logic [((4*(FRAC_BITS+2)+7)/8)*8-1:0] m_tdata
);

    localparam int QW    = FRAC_BITS + 2;
    localparam int OUT_W = ((4 * QW + 7) / 8) * 8;
    localparam int LAT   = 39;
    localparam int SH    = FX - FRAC_BITS;
    localparam logic [34:0] HALF_OUT = (35'd1 << SH) >> 1;
    localparam logic [34:0] LIM      = 35'd1 << FRAC_BITS;

    logic           en;
    logic [LAT-1:0] vld_reg, vld_next;
    sc_t            roll_sc, pitch_sc, yaw_sc;

    logic signed [63:0] pcc_reg, pcc_next, pss_reg, pss_next;
    logic signed [63:0] psc_reg, psc_next, pcs_reg, pcs_next;
    logic signed [31:0] cy1_reg, cy1_next, sy1_reg, sy1_next;
    logic signed [31:0] cc_reg, cc_next, ss_reg, ss_next;
    logic signed [31:0] sc_reg, sc_next, cs_reg, cs_next;
    logic signed [31:0] cy2_reg, cy2_next, sy2_reg, sy2_next;
    logic signed [63:0] pr_reg [8];
    logic signed [63:0] pr_next [8];
    logic signed [33:0] comp_reg [4];
    logic signed [33:0] comp_next [4];
    logic [QW-1:0]      q_reg [4];
    logic [QW-1:0]      q_next [4];
    logic [34:0]        mag;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    assign vld_next = en ? {vld_reg[LAT-2:0], s_tvalid} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    ezq_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_roll
    (
        .clk    (clk),
        .en     (en),
        .angle  (s_tdata[ANGLE_BITS-1:0]),
        .result (roll_sc)
    );

    ezq_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_pitch
    (
        .clk    (clk),
        .en     (en),
        .angle  (s_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .result (pitch_sc)
    );

    ezq_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_yaw
    (
        .clk    (clk),
        .en     (en),
        .angle  (s_tdata[3*ANGLE_BITS-1:2*ANGLE_BITS]),
        .result (yaw_sc)
    );

    always_comb
    begin
        pcc_next = 64'(roll_sc.cos_val) * 64'(pitch_sc.cos_val);
        pss_next = 64'(roll_sc.sin_val) * 64'(pitch_sc.sin_val);
        psc_next = 64'(roll_sc.sin_val) * 64'(pitch_sc.cos_val);
        pcs_next = 64'(roll_sc.cos_val) * 64'(pitch_sc.sin_val);
        cy1_next = yaw_sc.cos_val;
        sy1_next = yaw_sc.sin_val;

        cc_next  = 32'(rnd_q30(pcc_reg));
        ss_next  = 32'(rnd_q30(pss_reg));
        sc_next  = 32'(rnd_q30(psc_reg));
        cs_next  = 32'(rnd_q30(pcs_reg));
        cy2_next = cy1_reg;
        sy2_next = sy1_reg;

        pr_next[0] = 64'(cc_reg) * 64'(cy2_reg);
        pr_next[1] = 64'(ss_reg) * 64'(sy2_reg);
        pr_next[2] = 64'(sc_reg) * 64'(cy2_reg);
        pr_next[3] = 64'(cs_reg) * 64'(sy2_reg);
        pr_next[4] = 64'(cs_reg) * 64'(cy2_reg);
        pr_next[5] = 64'(sc_reg) * 64'(sy2_reg);
        pr_next[6] = 64'(cc_reg) * 64'(sy2_reg);
        pr_next[7] = 64'(ss_reg) * 64'(cy2_reg);

        comp_next[0] = 34'(rnd_q30(pr_reg[0]) + rnd_q30(pr_reg[1]));
        comp_next[1] = 34'(rnd_q30(pr_reg[2]) - rnd_q30(pr_reg[3]));
        comp_next[2] = 34'(rnd_q30(pr_reg[4]) + rnd_q30(pr_reg[5]));
        comp_next[3] = 34'(rnd_q30(pr_reg[6]) - rnd_q30(pr_reg[7]));

        mag = '0;
        for (int i = 0; i < 4; i++)
        begin
            mag = comp_reg[i][33] ? 35'(-comp_reg[i]) : 35'(comp_reg[i]);
            mag = (mag + HALF_OUT) >> SH;
            if (mag > LIM)
            begin
                mag = LIM;
            end
            q_next[i] = comp_reg[i][33] ? QW'(-mag) : QW'(mag);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcc_reg  <= pcc_next;
            pss_reg  <= pss_next;
            psc_reg  <= psc_next;
            pcs_reg  <= pcs_next;
            cy1_reg  <= cy1_next;
            sy1_reg  <= sy1_next;
            cc_reg   <= cc_next;
            ss_reg   <= ss_next;
            sc_reg   <= sc_next;
            cs_reg   <= cs_next;
            cy2_reg  <= cy2_next;
            sy2_reg  <= sy2_next;
            pr_reg   <= pr_next;
            comp_reg <= comp_next;
            q_reg    <= q_next;
        end
    end

    assign m_tdata = OUT_W'({q_reg[3], q_reg[2], q_reg[1], q_reg[0]});

endmodule

/* dv/euler_zyx_to_quaternion_top_test.sv */
// Self-checking bench for the Euler ZYX to quaternion block: directed table, then random angles.
`timescale 1ns / 1ps

module euler_zyx_to_quaternion_top_test;
    import ezq_pkg::*;

    localparam int AB = ANGLE_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int OW = FB + 2;
    localparam int N_RANDOM = 1250;

    typedef struct {
        logic [AB-1:0] roll;
        logic [AB-1:0] pitch;
        logic [AB-1:0] yaw;
        bit            known;
        logic [4*OW-1:0] quat;
    } angle_row_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [47:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [63:0] m_tdata;

    logic [4*OW-1:0] quat_queue[$];
    int errors;
    int send_idle_pct;
    int recv_stall_pct;
    angle_row_t rows[$];

    euler_zyx_to_quaternion_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    initial
    begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint shr_round(longint v, int s);
        longint h;
        h = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + h) >>> s;
        return -(((-v) + h) >>> s);
    endfunction

    function automatic longint div_round(longint v, longint d);
        if (v >= 0)
            return (v + d / 2) / d;
        return -(((-v) + d / 2) / d);
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return shr_round(a * b, FX);
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v < 0)
            return 0;
        if (v > (longint'(1) << FX))
            return longint'(1) << FX;
        return v;
    endfunction

    function automatic void half_sin_cos(input logic [AB-1:0] a, output longint s,
                                         output longint c);
        longint one;
        longint mag;
        longint x;
        longint x2;
        longint ts;
        longint tc;
        bit neg;
        one = longint'(1) << FX;
        neg = a[AB-1];
        mag = neg ? (longint'(1) << AB) - longint'(a) : longint'(a);
        x = (mag * longint'(PI_Q30) + (longint'(1) << (AB - 1))) >>> AB;
        x2 = q30_mul(x, x);
        ts = one;
        tc = one;
        for (int k = N_STEPS; k >= 1; k--)
        begin
            ts = one - div_round(q30_mul(x2, ts), (2 * k) * (2 * k + 1));
            tc = one - div_round(q30_mul(x2, tc), (2 * k - 1) * (2 * k));
        end
        s = unit_clamp(q30_mul(x, ts));
        if (neg)
            s = -s;
        c = unit_clamp(tc);
    endfunction

    function automatic logic [OW-1:0] to_q14(longint v);
        longint q;
        q = shr_round(v, FX - FB);
        if (q > (longint'(1) << FB))
            q = longint'(1) << FB;
        if (q < -(longint'(1) << FB))
            q = -(longint'(1) << FB);
        return q[OW-1:0];
    endfunction

    function automatic logic [4*OW-1:0] quat_of_euler(logic [AB-1:0] r, logic [AB-1:0] p,
                                                      logic [AB-1:0] y);
        longint sr, cr, sp, cp, sy, cy, cc, ss, sc, cs;
        longint qw, qx, qy, qz;
        half_sin_cos(r, sr, cr);
        half_sin_cos(p, sp, cp);
        half_sin_cos(y, sy, cy);
        cc = q30_mul(cr, cp);
        ss = q30_mul(sr, sp);
        sc = q30_mul(sr, cp);
        cs = q30_mul(cr, sp);
        qw = q30_mul(cc, cy) + q30_mul(ss, sy);
        qx = q30_mul(sc, cy) - q30_mul(cs, sy);
        qy = q30_mul(cs, cy) + q30_mul(sc, sy);
        qz = q30_mul(cc, sy) - q30_mul(ss, cy);
        return {to_q14(qz), to_q14(qy), to_q14(qx), to_q14(qw)};
    endfunction

    task automatic send_angles(input logic [AB-1:0] r, input logic [AB-1:0] p,
                               input logic [AB-1:0] y, input logic [4*OW-1:0] expected);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, p, r};
        quat_queue.push_back(expected);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (quat_queue.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual %h", $time, m_tdata);
                errors++;
            end
            else
            begin
                logic [4*OW-1:0] want;
                want = quat_queue.pop_front();
                for (int f = 0; f < 4; f++)
                    if (m_tdata[f*OW +: OW] !== want[f*OW +: OW])
                    begin
                        $display("%0t: field %0d expected %h actual %h", $time, f,
                                 want[f*OW +: OW], m_tdata[f*OW +: OW]);
                        errors++;
                    end
            end
        end
    end

    task automatic add_row(input int r, input int p, input int y, input bit known,
                           input logic [4*OW-1:0] q);
        angle_row_t row;
        row.roll = r[AB-1:0];
        row.pitch = p[AB-1:0];
        row.yaw = y[AB-1:0];
        row.known = known;
        row.quat = q;
        rows.push_back(row);
    endtask

    initial
    begin
        logic [AB-1:0] r, p, y;
        int wait_cycles;
        errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;

        // Zero rotation gives the identity; a half turn on one axis gives a pure axis part.
        add_row(0, 0, 0, 1, {16'd0, 16'd0, 16'd0, 16'd16384});
        add_row(-32768, 0, 0, 1, {16'd0, 16'd0, -16'sd16384, 16'd0});
        add_row(0, -32768, 0, 1, {16'd0, -16'sd16384, 16'd0, 16'd0});
        add_row(0, 0, -32768, 1, {-16'sd16384, 16'd0, 16'd0, 16'd0});
        add_row(-32768, -32768, -32768, 0, '0);
        add_row(32767, 32767, 32767, 0, '0);
        add_row(32767, -32768, 0, 0, '0);
        add_row(16384, 0, 0, 0, '0);
        add_row(0, 16384, 0, 0, '0);
        add_row(0, 0, 16384, 0, '0);
        add_row(-16384, -16384, -16384, 0, '0);
        add_row(1, -1, 1, 0, '0);
        add_row(-1, 1, -1, 0, '0);
        add_row(8192, -8192, 24576, 0, '0);
        add_row(21845, 10923, -5461, 0, '0);
        add_row(-32767, 32767, -32767, 0, '0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (rows[i])
            send_angles(rows[i].roll, rows[i].pitch, rows[i].yaw,
                        rows[i].known ? rows[i].quat
                                      : quat_of_euler(rows[i].roll, rows[i].pitch, rows[i].yaw));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            case ((i * 5) / N_RANDOM)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                3: begin send_idle_pct = 10; recv_stall_pct = 10; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            r = AB'($urandom());
            p = AB'($urandom());
            y = AB'($urandom());
            if ($urandom_range(9) == 0)
                r = $urandom_range(1) ? 16'h8000 : 16'h7fff;
            send_angles(r, p, y, quat_of_euler(r, p, y));
        end
        s_tvalid <= 1'b0;
        recv_stall_pct = 0;

        wait_cycles = 0;
        while (quat_queue.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (60) @(posedge clk);
        if (errors == 0 && quat_queue.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
